>>> design/sscd_pkg.sv
// sscd_pkg: shared types, constants and the six-step phase table
// for the commutation driver; no dependencies
`default_nettype none

package sscd_pkg;

    localparam int MAG_W  = 16;
    localparam int RPM_W  = 16;
    localparam int PROD_W = MAG_W + RPM_W;
    localparam int PER_W  = 29;
    localparam int STEP_W = 3;
    localparam int GATE_W = 6;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PER_W - 1);

    localparam logic [PER_W-1:0] PERIOD_NUM    = PER_W'((1 << 15) * 10000);
    localparam logic [RPM_W-1:0] MAX_RPM_RESET = RPM_W'(1000);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(5);

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_DIV,
        P_DONE
    } t_pu_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_WAIT,
        C_DONE
    } t_ctl_state;

    function automatic logic [GATE_W-1:0] phase_gates(input logic [STEP_W-1:0] step);
        logic [GATE_W-1:0] g;
        unique case (step)
            3'd0:    g = 6'b001001;
            3'd1:    g = 6'b011000;
            3'd2:    g = 6'b010010;
            3'd3:    g = 6'b000110;
            3'd4:    g = 6'b100100;
            3'd5:    g = 6'b100001;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

>>> design/six_step_commutation_driver.sv
// six_step_commutation_driver: six-step trapezoidal commutation for a
// brushless motor; uses sscd_pkg and sscd_period
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  kind, speed_cmd, bypass_limits, limit_bits
//   out       output     o_out_valid/i_out_stall gate_word, running, speed_now, step_now,
//                                                commutated
//   cfg       input      i_cfg_valid/o_cfg_ready max_rpm
//
// a tick or a zero/blocked command bypasses sscd_period; a nonzero command
// runs a serial multiply and then a serial divide in sscd_period
// synchronous active-low reset, no clearing pass; max_rpm resets to 1000
// one item in flight; while a result is held the next item is still taken,
// but its result waits and intake stalls until the held result leaves
`default_nettype none

module six_step_commutation_driver
    import sscd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_kind,
    input  wire logic signed [MAG_W-1:0]   i_speed_cmd,
    input  wire logic                      i_bypass_limits,
    input  wire logic [1:0]                i_limit_bits,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [GATE_W-1:0]              o_gate_word,
    output logic                           o_running,
    output logic [MAG_W-1:0]               o_speed_now,
    output logic [STEP_W-1:0]              o_step_now,
    output logic                           o_commutated,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [RPM_W-1:0]          i_cfg_data
);

    t_ctl_state          r_state, n_state;
    logic [RPM_W-1:0]    r_max_rpm;
    logic                r_dir;
    logic [MAG_W-1:0]    r_speed;
    logic [STEP_W-1:0]   r_step;
    logic [PER_W-1:0]    r_period;
    logic [PER_W-1:0]    r_tick;
    logic [GATE_W-1:0]   r_gate;
    logic                r_stepped;

    logic                r_out_valid;
    logic [GATE_W-1:0]   r_out_gate;
    logic                r_out_running;
    logic [MAG_W-1:0]    r_out_speed;
    logic [STEP_W-1:0]   r_out_step;
    logic                r_out_comm;

    logic                in_accept, out_free, load_out, pu_start, pu_done;
    logic [PER_W-1:0]    pu_period;
    logic [1:0]          blocks;
    logic                cmd_neg, cmd_set, cmd_dir;
    logic [MAG_W-1:0]    cmd_mag;
    logic                run;
    logic [PER_W-1:0]    tick_inc;
    logic                wrap;
    logic [STEP_W-1:0]   step_nxt;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // command decode with limit switches
    always_comb begin
        blocks  = i_bypass_limits ? 2'b00 : i_limit_bits;
        cmd_neg = i_speed_cmd[MAG_W-1];
        cmd_set = 1'b0;
        cmd_dir = 1'b0;
        cmd_mag = '0;
        if (cmd_neg && !blocks[1]) begin
            cmd_set = 1'b1;
            cmd_dir = 1'b0;
            cmd_mag = ~i_speed_cmd + MAG_W'(1);
        end else if (!cmd_neg && i_speed_cmd != '0 && !blocks[0]) begin
            cmd_set = 1'b1;
            cmd_dir = 1'b1;
            cmd_mag = i_speed_cmd;
        end
    end

    // tick path
    always_comb begin
        run      = (r_speed != '0);
        tick_inc = r_tick + PER_W'(1);
        wrap     = (tick_inc >= r_period);
        if (r_dir) begin
            step_nxt = (r_step >= STEP_LAST) ? '0 : r_step + STEP_W'(1);
        end else begin
            step_nxt = (r_step == '0 || r_step > STEP_LAST) ? STEP_LAST
                                                            : r_step - STEP_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (in_accept) begin
                    n_state = (i_kind == KIND_CMD && cmd_set) ? C_WAIT : C_DONE;
                end
            end
            C_WAIT:  if (pu_done) n_state = C_DONE;
            C_DONE:  if (out_free) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != C_IDLE);
        load_out   = (r_state == C_DONE) && out_free;
        pu_start   = in_accept && i_kind == KIND_CMD && cmd_set;
    end

    sscd_period u_period (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (pu_start),
        .i_mag    (cmd_mag),
        .i_rpm    (r_max_rpm),
        .o_done   (pu_done),
        .o_period (pu_period)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_max_rpm   <= MAX_RPM_RESET;
            r_dir       <= 1'b0;
            r_speed     <= '0;
            r_step      <= '0;
            r_period    <= '0;
            r_tick      <= '0;
            r_gate      <= '0;
            r_stepped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_rpm <= i_cfg_data;
            end
            if (in_accept) begin
                case (i_kind)
                    KIND_TICK: begin
                        r_stepped <= run && wrap;
                        if (run) begin
                            if (wrap) begin
                                r_tick <= '0;
                                r_step <= step_nxt;
                                r_gate <= phase_gates(step_nxt);
                            end else begin
                                r_tick <= tick_inc;
                            end
                        end
                    end
                    default: begin
                        r_stepped <= 1'b0;
                        r_speed   <= cmd_mag;
                        if (cmd_set) begin
                            r_dir <= cmd_dir;
                        end else begin
                            r_period <= '0;
                            r_gate   <= '0;
                        end
                    end
                endcase
            end
            if (pu_done) begin
                r_period <= pu_period;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_gate    <= r_gate;
            r_out_running <= run;
            r_out_speed   <= r_speed;
            r_out_step    <= r_step;
            r_out_comm    <= r_stepped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_gate_word  = r_out_gate;
    assign o_running    = r_out_running;
    assign o_speed_now  = r_out_speed;
    assign o_step_now   = r_out_step;
    assign o_commutated = r_out_comm;

endmodule

`default_nettype wire

>>> design/sscd_period.sv
// sscd_period: commutation period unit, bit-serial multiply of speed by
// max_rpm, then restoring divide of the fixed numerator; uses sscd_pkg
`default_nettype none

module sscd_period
    import sscd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MAG_W-1:0]   i_mag,
    input  wire logic [RPM_W-1:0]   i_rpm,
    output logic                    o_done,
    output logic [PER_W-1:0]        o_period
);

    t_pu_state           r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [RPM_W-1:0]    r_mcand;
    logic [PROD_W-1:0]   r_prod;
    logic [PER_W-1:0]    r_quo;
    logic [PROD_W-1:0]   r_rem;

    logic                mul_en, div_en;
    logic [MAG_W:0]      mul_sum;
    logic [PROD_W-1:0]   div_shift;
    logic [PROD_W:0]     div_diff;
    logic                div_ge;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE: if (i_start) n_state = P_MUL;
            P_MUL:  if (r_cnt == MUL_LAST) n_state = P_DIV;
            P_DIV:  if (r_cnt == DIV_LAST) n_state = P_DONE;
            P_DONE: n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    always_comb begin
        mul_en = (r_state == P_MUL);
        div_en = (r_state == P_DIV);
        o_done = (r_state == P_DONE);
    end

    assign o_period = r_quo;

    // one multiplier bit per cycle, product grows from the top
    assign mul_sum = {1'b0, r_prod[PROD_W-1:MAG_W]}
                   + (r_prod[0] ? {1'b0, r_mcand} : '0);

    // one quotient bit per cycle
    assign div_shift = {r_rem[PROD_W-2:0], r_quo[PER_W-1]};
    assign div_diff  = {1'b0, div_shift} - {1'b0, r_prod};
    assign div_ge    = !div_diff[PROD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_start || (mul_en && r_cnt == MUL_LAST)) begin
                r_cnt <= '0;
            end else if (mul_en || div_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= (i_rpm == '0) ? RPM_W'(1) : i_rpm;
            r_prod  <= {{RPM_W{1'b0}}, i_mag};
            r_quo   <= PERIOD_NUM;
            r_rem   <= '0;
        end else if (mul_en) begin
            r_prod <= {mul_sum, r_prod[MAG_W-1:1]};
        end else if (div_en) begin
            r_rem <= div_ge ? div_diff[PROD_W-1:0] : div_shift;
            r_quo <= {r_quo[PER_W-2:0], div_ge};
        end
    end

endmodule

`default_nettype wire
